// File: sv/vau_pkg.sv
`default_nettype none

package vau_pkg;

   localparam logic [2:0] FN_DOT    = 3'd0;
   localparam logic [2:0] FN_CROSS  = 3'd1;
   localparam logic [2:0] FN_SUB    = 3'd2;
   localparam logic [2:0] FN_MAG    = 3'd3;
   localparam logic [2:0] FN_UNIT   = 3'd4;
   localparam logic [2:0] FN_SPHERE = 3'd5;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_SAT    = 2'd1;
   localparam logic [1:0] ST_NOROOT = 2'd2;
   localparam logic [1:0] ST_ZERO   = 2'd3;

   localparam logic [31:0] MAX32 = 32'h7FFF_FFFF;
   localparam logic [31:0] MIN32 = 32'h8000_0000;

   typedef struct packed {
      logic        ovf;
      logic [31:0] val;
   } sat_type;

   typedef struct packed {
      logic [2:0]       func;
      logic             plus;
      logic             sat;
      logic             noroot;
      logic             zero;
      logic [2:0]       sgn;
      logic [31:0]      d;
      logic [2:0][31:0] vec;
   } ctx_type;

   function automatic sat_type sat32(input logic signed [65:0] v);
      sat_type r;
      if (v[65:31] != {35{v[65]}}) begin
         r.ovf = 1'b1;
         r.val = v[65] ? MIN32 : MAX32;
      end else begin
         r.ovf = 1'b0;
         r.val = v[31:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// File: sv/vau_sqrt.sv
`default_nettype none

module vau_sqrt (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_vld,
   input  logic [63:0]       in_op,
   input  vau_pkg::ctx_type  in_ctx,
   output logic              out_vld,
   output logic [31:0]       out_root,
   output vau_pkg::ctx_type  out_ctx
);

   localparam int NS = 32;

   logic             vld_ff  [NS];
   logic [32:0]      rem_ff  [NS];
   logic [31:0]      root_ff [NS];
   logic [63:0]      x_ff    [NS];
   vau_pkg::ctx_type ctx_ff  [NS];

   for (genvar i = 0; i < NS; i++) begin : g_stage
      logic             src_vld;
      logic [32:0]      src_rem;
      logic [31:0]      src_root;
      logic [63:0]      src_x;
      vau_pkg::ctx_type src_ctx;
      logic [34:0]      rem_sh;
      logic [34:0]      trial;
      logic             ge;

      if (i == 0) begin : g_first
         assign src_vld  = in_vld;
         assign src_rem  = '0;
         assign src_root = '0;
         assign src_x    = in_op;
         assign src_ctx  = in_ctx;
      end else begin : g_next
         assign src_vld  = vld_ff[i-1];
         assign src_rem  = rem_ff[i-1];
         assign src_root = root_ff[i-1];
         assign src_x    = x_ff[i-1];
         assign src_ctx  = ctx_ff[i-1];
      end

      assign rem_sh = {src_rem, src_x[63:62]};
      assign trial  = {1'b0, src_root, 2'b01};
      assign ge     = (rem_sh >= trial);

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (en) begin
            vld_ff[i] <= src_vld;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i]  <= ge ? 33'(rem_sh - trial) : rem_sh[32:0];
            root_ff[i] <= {src_root[30:0], ge};
            x_ff[i]    <= {src_x[61:0], 2'b00};
            ctx_ff[i]  <= src_ctx;
         end
      end
   end

   assign out_vld  = vld_ff[NS-1];
   assign out_root = root_ff[NS-1];
   assign out_ctx  = ctx_ff[NS-1];

endmodule

`default_nettype wire

// File: sv/vau_div.sv
`default_nettype none

module vau_div #(
   parameter int FRAC_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_vld,
   input  logic [31:0]                in_den,
   input  vau_pkg::ctx_type           in_ctx,
   output logic                       out_vld,
   output logic [31:0]                out_den,
   output vau_pkg::ctx_type           out_ctx,
   output logic [2:0][FRAC_BITS:0]    out_quo
);

   localparam int NQ = FRAC_BITS + 1;

   logic                  vld_ff [NQ];
   logic [2:0][32:0]      rem_ff [NQ];
   logic [2:0][NQ-1:0]    quo_ff [NQ];
   logic [31:0]           den_ff [NQ];
   vau_pkg::ctx_type      ctx_ff [NQ];

   for (genvar j = 0; j < NQ; j++) begin : g_stage
      logic               src_vld;
      logic [2:0][32:0]   src_rem;
      logic [2:0][NQ-1:0] src_quo;
      logic [31:0]        src_den;
      vau_pkg::ctx_type   src_ctx;
      logic [2:0][32:0]   rem_in;
      logic [2:0][NQ-1:0] quo_in;

      if (j == 0) begin : g_first
         assign src_vld = in_vld;
         assign src_den = in_den;
         assign src_ctx = in_ctx;
         assign src_quo = '0;
         for (genvar l = 0; l < 3; l++) begin : g_lane
            assign src_rem[l] = {1'b0, in_ctx.vec[l]};
         end
      end else begin : g_next
         assign src_vld = vld_ff[j-1];
         assign src_den = den_ff[j-1];
         assign src_ctx = ctx_ff[j-1];
         assign src_quo = quo_ff[j-1];
         assign src_rem = rem_ff[j-1];
      end

      always_comb begin
         logic        ge;
         logic [32:0] diff;
         logic [31:0] nxt;
         for (int l = 0; l < 3; l++) begin
            ge        = (src_rem[l] >= {1'b0, src_den});
            diff      = src_rem[l] - {1'b0, src_den};
            nxt       = ge ? diff[31:0] : src_rem[l][31:0];
            rem_in[l] = {nxt, 1'b0};
            quo_in[l] = {src_quo[l][NQ-2:0], ge};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else if (en) begin
            vld_ff[j] <= src_vld;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j] <= rem_in;
            quo_ff[j] <= quo_in;
            den_ff[j] <= src_den;
            ctx_ff[j] <= src_ctx;
         end
      end
   end

   assign out_vld = vld_ff[NQ-1];
   assign out_den = den_ff[NQ-1];
   assign out_ctx = ctx_ff[NQ-1];
   assign out_quo = quo_ff[NQ-1];

endmodule

`default_nettype wire

// File: sv/vector3_arith_unit_top.sv
// 3-vector arithmetic unit on signed fixed point with FRAC_BITS fraction bits.
// Request channel (req_*): valid/ready; one item carries the operation code,
// vectors a and b, a sphere radius and the root sign choice.
// Response channel (rsp_*): valid/ready; each item yields exactly one result
// with vector and scalar fields and a status code.
// Throughput: one item per cycle while the output is not stalled. Five
// arithmetic stages feed a 32-stage square-root pipeline, one result bit per
// stage, then a FRAC_BITS + 1 stage divider with three lanes, one quotient
// bit per stage, then the output register. Every operation runs through the
// same stages.
// Reset: synchronous, active high; clears all stage valid bits, so no
// response is pending afterwards.
// Stall: while a response waits unaccepted the whole pipeline holds and
// req_ready is low; no item is dropped or repeated.
`default_nettype none

module vector3_arith_unit_top #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_func,
   input  logic signed [31:0] req_a_x,
   input  logic signed [31:0] req_a_y,
   input  logic signed [31:0] req_a_z,
   input  logic signed [31:0] req_b_x,
   input  logic signed [31:0] req_b_y,
   input  logic signed [31:0] req_b_z,
   input  logic [30:0]        req_radius,
   input  logic               req_take_plus_root,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_res_x,
   output logic signed [31:0] rsp_res_y,
   output logic signed [31:0] rsp_res_z,
   output logic signed [31:0] rsp_res_scalar,
   output logic [1:0]         rsp_status
);

   logic en;
   logic signed [31:0] av [3];
   logic signed [31:0] bv [3];

   assign av[0] = req_a_x;
   assign av[1] = req_a_y;
   assign av[2] = req_a_z;
   assign bv[0] = req_b_x;
   assign bv[1] = req_b_y;
   assign bv[2] = req_b_z;

   // stage A: products, differences
   logic               a_vld_ff;
   logic [2:0]         a_func_ff;
   logic               a_plus_ff;
   logic [30:0]        a_rad_ff;
   logic signed [31:0] a_av_ff  [3];
   logic signed [63:0] a_pd_ff  [3];
   logic signed [63:0] a_pd_in  [3];
   logic signed [63:0] a_pc_ff  [6];
   logic signed [63:0] a_pc_in  [6];
   logic [31:0]        a_dif_ff [3];
   logic [31:0]        a_dif_in [3];
   logic               a_dsat_ff;
   logic               a_dsat_in;
   logic [62:0]        a_sqa_ff [3];
   logic [62:0]        a_sqa_in [3];
   logic [62:0]        a_sqb_ff [3];
   logic [62:0]        a_sqb_in [3];

   always_comb begin
      logic signed [32:0] dd;
      logic signed [63:0] sa;
      logic signed [63:0] sb;
      a_dsat_in = 1'b0;
      for (int i = 0; i < 3; i++) begin
         a_pd_in[i] = av[i] * bv[i];
         dd = {bv[i][31], bv[i]} - {av[i][31], av[i]};
         if (dd[32] != dd[31]) begin
            a_dif_in[i] = dd[32] ? vau_pkg::MIN32 : vau_pkg::MAX32;
            a_dsat_in   = 1'b1;
         end else begin
            a_dif_in[i] = dd[31:0];
         end
         sa = av[i] * av[i];
         sb = bv[i] * bv[i];
         a_sqa_in[i] = sa[62:0];
         a_sqb_in[i] = sb[62:0];
      end
      a_pc_in[0] = av[1] * bv[2];
      a_pc_in[1] = bv[1] * av[2];
      a_pc_in[2] = av[2] * bv[0];
      a_pc_in[3] = bv[2] * av[0];
      a_pc_in[4] = av[0] * bv[1];
      a_pc_in[5] = bv[0] * av[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (en) begin
         a_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_func_ff <= req_func;
         a_plus_ff <= req_take_plus_root;
         a_rad_ff  <= req_radius;
         a_av_ff   <= av;
         a_pd_ff   <= a_pd_in;
         a_pc_ff   <= a_pc_in;
         a_dif_ff  <= a_dif_in;
         a_dsat_ff <= a_dsat_in;
         a_sqa_ff  <= a_sqa_in;
         a_sqb_ff  <= a_sqb_in;
      end
   end

   // stage B: dot, cross, sums of squares, unit normalization shift
   logic             b_vld_ff;
   vau_pkg::ctx_type b_ctx_ff;
   vau_pkg::ctx_type b_ctx_in;
   logic [30:0]      b_rad_ff;
   logic [63:0]      b_ssa_ff;
   logic [63:0]      b_ssa_in;
   logic [63:0]      b_tt_ff;
   logic [63:0]      b_tt_in;
   logic [31:0]      b_mag_ff [3];
   logic [31:0]      b_mag_in [3];
   logic [4:0]       b_k_ff;
   logic [4:0]       b_k_in;

   always_comb begin
      logic signed [65:0] dsum;
      logic signed [64:0] cd;
      vau_pkg::sat_type   dotr;
      vau_pkg::sat_type   cr;
      logic               csat;
      logic [2:0][31:0]   cvec;
      logic [31:0]        mx;
      logic [31:0]        m;
      dsum = 66'(a_pd_ff[0]) + 66'(a_pd_ff[1]) + 66'(a_pd_ff[2]);
      dotr = vau_pkg::sat32(dsum >>> FRAC_BITS);
      csat = 1'b0;
      for (int i = 0; i < 3; i++) begin
         cd      = 65'(a_pc_ff[2*i]) - 65'(a_pc_ff[2*i+1]);
         cr      = vau_pkg::sat32(66'(cd >>> FRAC_BITS));
         cvec[i] = cr.val;
         csat    = csat | cr.ovf;
      end
      b_ssa_in = 64'(a_sqa_ff[0]) + 64'(a_sqa_ff[1]) + 64'(a_sqa_ff[2]);
      b_tt_in  = 64'(a_sqb_ff[0]) + 64'(a_sqb_ff[1]) + 64'(a_sqb_ff[2]);
      mx = '0;
      for (int i = 0; i < 3; i++) begin
         b_mag_in[i] = a_av_ff[i][31] ? 32'(-a_av_ff[i]) : a_av_ff[i];
         if (b_mag_in[i] > mx) begin
            mx = b_mag_in[i];
         end
      end
      m      = mx;
      b_k_in = '0;
      for (int j = 4; j >= 0; j--) begin
         if (m < (32'h1 << (31 - (1 << j)))) begin
            m      = m << (1 << j);
            b_k_in = b_k_in | 5'(1 << j);
         end
      end
      b_ctx_in.func   = a_func_ff;
      b_ctx_in.plus   = a_plus_ff;
      b_ctx_in.noroot = 1'b0;
      b_ctx_in.zero   = (mx == '0);
      b_ctx_in.sgn    = {a_av_ff[2][31], a_av_ff[1][31], a_av_ff[0][31]};
      b_ctx_in.d      = dotr.val;
      b_ctx_in.vec    = '0;
      b_ctx_in.sat    = 1'b0;
      if (a_func_ff == vau_pkg::FN_DOT || a_func_ff == vau_pkg::FN_SPHERE) begin
         b_ctx_in.sat = dotr.ovf;
      end else if (a_func_ff == vau_pkg::FN_CROSS) begin
         b_ctx_in.sat = csat;
         b_ctx_in.vec = cvec;
      end else if (a_func_ff == vau_pkg::FN_SUB) begin
         b_ctx_in.sat = a_dsat_ff;
         b_ctx_in.vec = {a_dif_ff[2], a_dif_ff[1], a_dif_ff[0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else if (en) begin
         b_vld_ff <= a_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_ctx_ff <= b_ctx_in;
         b_rad_ff <= a_rad_ff;
         b_ssa_ff <= b_ssa_in;
         b_tt_ff  <= b_tt_in;
         b_mag_ff <= b_mag_in;
         b_k_ff   <= b_k_in;
      end
   end

   // stage C: d^2, r^2, scaled magnitudes
   logic             c_vld_ff;
   vau_pkg::ctx_type c_ctx_ff;
   vau_pkg::ctx_type c_ctx_in;
   logic [62:0]      c_d2_ff;
   logic [62:0]      c_d2_in;
   logic [61:0]      c_r2_ff;
   logic [61:0]      c_r2_in;
   logic [63:0]      c_ssa_ff;
   logic [63:0]      c_tt_ff;

   always_comb begin
      logic signed [63:0] dp;
      dp       = $signed(b_ctx_ff.d) * $signed(b_ctx_ff.d);
      c_d2_in  = dp[62:0];
      c_r2_in  = b_rad_ff * b_rad_ff;
      c_ctx_in = b_ctx_ff;
      if (b_ctx_ff.func == vau_pkg::FN_UNIT) begin
         for (int i = 0; i < 3; i++) begin
            c_ctx_in.vec[i] = b_mag_ff[i] << b_k_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else if (en) begin
         c_vld_ff <= b_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_ctx_ff <= c_ctx_in;
         c_d2_ff  <= c_d2_in;
         c_r2_ff  <= c_r2_in;
         c_ssa_ff <= b_ssa_ff;
         c_tt_ff  <= b_tt_ff;
      end
   end

   // stage D: d^2 + r^2, squares of scaled vector
   logic             d_vld_ff;
   vau_pkg::ctx_type d_ctx_ff;
   logic [63:0]      d_pos_ff;
   logic [63:0]      d_pos_in;
   logic [63:0]      d_sqs_ff [3];
   logic [63:0]      d_sqs_in [3];
   logic [63:0]      d_ssa_ff;
   logic [63:0]      d_tt_ff;

   always_comb begin
      d_pos_in = {1'b0, c_d2_ff} + {2'b00, c_r2_ff};
      for (int i = 0; i < 3; i++) begin
         d_sqs_in[i] = c_ctx_ff.vec[i] * c_ctx_ff.vec[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_vld_ff <= 1'b0;
      end else if (en) begin
         d_vld_ff <= c_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_ctx_ff <= c_ctx_ff;
         d_pos_ff <= d_pos_in;
         d_sqs_ff <= d_sqs_in;
         d_ssa_ff <= c_ssa_ff;
         d_tt_ff  <= c_tt_ff;
      end
   end

   // stage E: discriminant, root operand select
   logic             e_vld_ff;
   vau_pkg::ctx_type e_ctx_ff;
   vau_pkg::ctx_type e_ctx_in;
   logic [63:0]      e_op_ff;
   logic [63:0]      e_op_in;

   always_comb begin
      logic        lt;
      logic [63:0] sums;
      lt       = (d_pos_ff < d_tt_ff);
      sums     = d_sqs_ff[0] + d_sqs_ff[1] + d_sqs_ff[2];
      e_ctx_in = d_ctx_ff;
      e_ctx_in.noroot = (d_ctx_ff.func == vau_pkg::FN_SPHERE) && lt;
      case (d_ctx_ff.func)
         vau_pkg::FN_MAG:    e_op_in = d_ssa_ff;
         vau_pkg::FN_UNIT:   e_op_in = sums;
         vau_pkg::FN_SPHERE: e_op_in = lt ? '0 : d_pos_ff - d_tt_ff;
         default:            e_op_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_vld_ff <= 1'b0;
      end else if (en) begin
         e_vld_ff <= d_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e_ctx_ff <= e_ctx_in;
         e_op_ff  <= e_op_in;
      end
   end

   logic                   s_vld;
   logic [31:0]            s_root;
   vau_pkg::ctx_type       s_ctx;
   logic                   q_vld;
   logic [31:0]            q_root;
   vau_pkg::ctx_type       q_ctx;
   logic [2:0][FRAC_BITS:0] q_quo;

   vau_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (e_vld_ff),
      .in_op    (e_op_ff),
      .in_ctx   (e_ctx_ff),
      .out_vld  (s_vld),
      .out_root (s_root),
      .out_ctx  (s_ctx)
   );

   vau_div #(
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_vld  (s_vld),
      .in_den  (s_root),
      .in_ctx  (s_ctx),
      .out_vld (q_vld),
      .out_den (q_root),
      .out_ctx (q_ctx),
      .out_quo (q_quo)
   );

   // output register
   logic        out_vld_ff;
   logic [31:0] out_x_ff;
   logic [31:0] out_x_in;
   logic [31:0] out_y_ff;
   logic [31:0] out_y_in;
   logic [31:0] out_z_ff;
   logic [31:0] out_z_in;
   logic [31:0] out_sc_ff;
   logic [31:0] out_sc_in;
   logic [1:0]  out_st_ff;
   logic [1:0]  out_st_in;

   always_comb begin
      logic [2:0][31:0]   uv;
      logic [31:0]        qx;
      logic signed [33:0] t;
      vau_pkg::sat_type   tr;
      for (int i = 0; i < 3; i++) begin
         qx    = 32'(q_quo[i]);
         uv[i] = q_ctx.sgn[i] ? 32'(-qx) : qx;
      end
      if (q_ctx.plus) begin
         t = $signed({{2{q_ctx.d[31]}}, q_ctx.d}) + $signed({2'b00, q_root});
      end else begin
         t = $signed({{2{q_ctx.d[31]}}, q_ctx.d}) - $signed({2'b00, q_root});
      end
      tr        = vau_pkg::sat32(66'(t));
      out_x_in  = '0;
      out_y_in  = '0;
      out_z_in  = '0;
      out_sc_in = '0;
      out_st_in = vau_pkg::ST_OK;
      case (q_ctx.func)
         vau_pkg::FN_DOT: begin
            out_sc_in = q_ctx.d;
            out_st_in = q_ctx.sat ? vau_pkg::ST_SAT : vau_pkg::ST_OK;
         end
         vau_pkg::FN_CROSS, vau_pkg::FN_SUB: begin
            out_x_in  = q_ctx.vec[0];
            out_y_in  = q_ctx.vec[1];
            out_z_in  = q_ctx.vec[2];
            out_st_in = q_ctx.sat ? vau_pkg::ST_SAT : vau_pkg::ST_OK;
         end
         vau_pkg::FN_MAG: begin
            out_sc_in = q_root[31] ? vau_pkg::MAX32 : q_root;
            out_st_in = q_root[31] ? vau_pkg::ST_SAT : vau_pkg::ST_OK;
         end
         vau_pkg::FN_UNIT: begin
            if (q_ctx.zero) begin
               out_st_in = vau_pkg::ST_ZERO;
            end else begin
               out_x_in = uv[0];
               out_y_in = uv[1];
               out_z_in = uv[2];
            end
         end
         vau_pkg::FN_SPHERE: begin
            if (q_ctx.noroot) begin
               out_st_in = vau_pkg::ST_NOROOT;
            end else begin
               out_sc_in = tr.val;
               out_st_in = (q_ctx.sat || tr.ovf) ? vau_pkg::ST_SAT : vau_pkg::ST_OK;
            end
         end
         default: begin
            out_st_in = vau_pkg::ST_OK;
         end
      endcase
   end

   assign en = !out_vld_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (en) begin
         out_vld_ff <= q_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_x_ff  <= out_x_in;
         out_y_ff  <= out_y_in;
         out_z_ff  <= out_z_in;
         out_sc_ff <= out_sc_in;
         out_st_ff <= out_st_in;
      end
   end

   assign req_ready      = en;
   assign rsp_valid      = out_vld_ff;
   assign rsp_res_x      = out_x_ff;
   assign rsp_res_y      = out_y_ff;
   assign rsp_res_z      = out_z_ff;
   assign rsp_res_scalar = out_sc_ff;
   assign rsp_status     = out_st_ff;

endmodule

`default_nettype wire

// File: sv/vau_chk.sv
`default_nettype none

module vau_chk (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [31:0] rsp_res_x,
   input logic signed [31:0] rsp_res_y,
   input logic signed [31:0] rsp_res_z,
   input logic signed [31:0] rsp_res_scalar,
   input logic [1:0]         rsp_status
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_res_scalar)
         && $stable(rsp_status))
      else $error("stalled response changed");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("item taken while output stalled");

   a_noroot_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == vau_pkg::ST_NOROOT |-> rsp_res_scalar == 0
         && rsp_res_x == 0 && rsp_res_y == 0 && rsp_res_z == 0)
      else $error("no-root result not zero");

   a_zero_mag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == vau_pkg::ST_ZERO |-> rsp_res_scalar == 0
         && rsp_res_x == 0 && rsp_res_y == 0 && rsp_res_z == 0)
      else $error("zero-magnitude result not zero");

endmodule

bind vector3_arith_unit_top vau_chk u_vau_chk (.*);

`default_nettype wire

// File: dv/tb_vector3_arith_unit_top.sv
module tb_vector3_arith_unit_top;

   localparam int FRAC = 16;
   localparam int CYCLE_LIMIT = 400000;
   localparam int TAIL_CYCLES = 120;

   typedef struct packed {
      logic [31:0] res_x;
      logic [31:0] res_y;
      logic [31:0] res_z;
      logic [31:0] res_scalar;
      logic [1:0]  status;
   } vau_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [2:0]         req_func = '0;
   logic signed [31:0] req_a_x = '0;
   logic signed [31:0] req_a_y = '0;
   logic signed [31:0] req_a_z = '0;
   logic signed [31:0] req_b_x = '0;
   logic signed [31:0] req_b_y = '0;
   logic signed [31:0] req_b_z = '0;
   logic [30:0]        req_radius = '0;
   logic               req_take_plus_root = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [31:0] rsp_res_x;
   logic signed [31:0] rsp_res_y;
   logic signed [31:0] rsp_res_z;
   logic signed [31:0] rsp_res_scalar;
   logic [1:0]         rsp_status;

   vau_result_type exp_mem [int];
   int             exp_wr_idx = 0;
   int             exp_rd_idx = 0;
   int             error_count = 0;
   int             cycle_count = 0;
   int             send_idle_pct = 0;
   int             recv_idle_pct = 0;

   vector3_arith_unit_top #(.FRAC_BITS(FRAC)) DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_func(req_func),
      .req_a_x(req_a_x), .req_a_y(req_a_y), .req_a_z(req_a_z),
      .req_b_x(req_b_x), .req_b_y(req_b_y), .req_b_z(req_b_z),
      .req_radius(req_radius), .req_take_plus_root(req_take_plus_root),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_res_x(rsp_res_x), .rsp_res_y(rsp_res_y), .rsp_res_z(rsp_res_z),
      .rsp_res_scalar(rsp_res_scalar), .rsp_status(rsp_status)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   function automatic logic [127:0] isqrt128(input logic [127:0] x);
      logic [127:0] res;
      logic [127:0] bitv;
      res = '0;
      bitv = 128'd1 << 126;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x = x - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic logic [31:0] clamp_to_i32(input logic signed [127:0] v,
                                                inout logic flag);
      if (v > 128'sh7FFF_FFFF) begin
         flag = 1'b1;
         return vau_pkg::MAX32;
      end
      if (v < -128'sh8000_0000) begin
         flag = 1'b1;
         return vau_pkg::MIN32;
      end
      return v[31:0];
   endfunction

   function automatic logic [127:0] abs128(input logic signed [127:0] v);
      return v < 0 ? -v : v;
   endfunction

   function automatic vau_result_type compute_vau(
      input logic [2:0] func,
      input logic signed [31:0] ax, ay, az, bx, by, bz,
      input logic [30:0] radius, input logic plus);
      vau_result_type      r;
      logic signed [127:0] a[3], b[3], d, root;
      logic [127:0]        mx, m, pos, tt, q, sm[3];
      logic                sat;
      int                  k;
      r = '0;
      sat = 1'b0;
      a[0] = ax; a[1] = ay; a[2] = az;
      b[0] = bx; b[1] = by; b[2] = bz;
      case (func)
         vau_pkg::FN_DOT: begin
            r.res_scalar = clamp_to_i32((a[0]*b[0] + a[1]*b[1] + a[2]*b[2]) >>> FRAC, sat);
         end
         vau_pkg::FN_CROSS: begin
            r.res_x = clamp_to_i32((a[1]*b[2] - b[1]*a[2]) >>> FRAC, sat);
            r.res_y = clamp_to_i32((a[2]*b[0] - b[2]*a[0]) >>> FRAC, sat);
            r.res_z = clamp_to_i32((a[0]*b[1] - b[0]*a[1]) >>> FRAC, sat);
         end
         vau_pkg::FN_SUB: begin
            r.res_x = clamp_to_i32(b[0] - a[0], sat);
            r.res_y = clamp_to_i32(b[1] - a[1], sat);
            r.res_z = clamp_to_i32(b[2] - a[2], sat);
         end
         vau_pkg::FN_MAG: begin
            r.res_scalar = clamp_to_i32(isqrt128(a[0]*a[0] + a[1]*a[1] + a[2]*a[2]), sat);
         end
         vau_pkg::FN_UNIT: begin
            mx = 0;
            for (int i = 0; i < 3; i++) if (abs128(a[i]) > mx) mx = abs128(a[i]);
            if (mx == 0) begin
               r.status = vau_pkg::ST_ZERO;
            end else begin
               k = 0;
               while (mx < (128'd1 << 30)) begin
                  mx = mx << 1;
                  k++;
               end
               for (int i = 0; i < 3; i++) sm[i] = abs128(a[i]) << k;
               m = isqrt128(sm[0]*sm[0] + sm[1]*sm[1] + sm[2]*sm[2]);
               q = (sm[0] << FRAC) / m;
               r.res_x = a[0] < 0 ? -q[31:0] : q[31:0];
               q = (sm[1] << FRAC) / m;
               r.res_y = a[1] < 0 ? -q[31:0] : q[31:0];
               q = (sm[2] << FRAC) / m;
               r.res_z = a[2] < 0 ? -q[31:0] : q[31:0];
            end
         end
         vau_pkg::FN_SPHERE: begin
            d = $signed(clamp_to_i32((a[0]*b[0] + a[1]*b[1] + a[2]*b[2]) >>> FRAC, sat));
            pos = abs128(d) * abs128(d) + 128'(radius) * 128'(radius);
            tt = b[0]*b[0] + b[1]*b[1] + b[2]*b[2];
            if (pos < tt) begin
               r.status = vau_pkg::ST_NOROOT;
               sat = 1'b0;
            end else begin
               root = isqrt128(pos - tt);
               r.res_scalar = clamp_to_i32(plus ? d + root : d - root, sat);
            end
         end
         default: ;
      endcase
      if (sat && r.status == vau_pkg::ST_OK) r.status = vau_pkg::ST_SAT;
      return r;
   endfunction

   task automatic record_expected(input vau_result_type r);
      exp_mem[exp_wr_idx] = r;
      exp_wr_idx++;
   endtask

   task automatic send_item(input logic [2:0] func,
                            input logic signed [31:0] ax, ay, az, bx, by, bz,
                            input logic [30:0] radius, input logic plus);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_func = func;
      req_a_x = ax; req_a_y = ay; req_a_z = az;
      req_b_x = bx; req_b_y = by; req_b_z = bz;
      req_radius = radius;
      req_take_plus_root = plus;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      record_expected(compute_vau(func, ax, ay, az, bx, by, bz, radius, plus));
   endtask

   task automatic compare_field(input string name, input logic [31:0] expv,
                                input logic [31:0] actv);
      if (expv !== actv) begin
         error_count++;
         $display("%0t %s: expected %h actual %h", $time, name, expv, actv);
      end
   endtask

   always @(posedge clock) begin
      vau_result_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (exp_rd_idx == exp_wr_idx) begin
            error_count++;
            $display("%0t unexpected item: actual %h %h %h %h %h", $time, rsp_res_x,
                     rsp_res_y, rsp_res_z, rsp_res_scalar, rsp_status);
         end else begin
            e = exp_mem[exp_rd_idx];
            exp_mem.delete(exp_rd_idx);
            exp_rd_idx++;
            compare_field("res_x", e.res_x, rsp_res_x);
            compare_field("res_y", e.res_y, rsp_res_y);
            compare_field("res_z", e.res_z, rsp_res_z);
            compare_field("res_scalar", e.res_scalar, rsp_res_scalar);
            compare_field("status", 32'(e.status), 32'(rsp_status));
         end
      end
   end

   function automatic logic [31:0] rand_comp();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
         2: return 32'($signed($urandom_range(0, 1 << 17)) - (1 << 16));
         3: return $urandom_range(0, 1) ? vau_pkg::MAX32 : vau_pkg::MIN32;
         4: return 32'($signed($urandom_range(0, 4)) - 2);
         default: return $urandom() >>> $urandom_range(0, 31);
      endcase
   endfunction

   task automatic test_directed();
      logic [2:0] f;
      for (int i = 0; i < 8; i++) begin
         f = 3'(i);
         send_item(f, vau_pkg::MAX32, vau_pkg::MAX32, vau_pkg::MAX32, vau_pkg::MIN32,
                   vau_pkg::MIN32, vau_pkg::MIN32, 31'h7FFF_FFFF, 1'b1);
         send_item(f, vau_pkg::MIN32, vau_pkg::MIN32, vau_pkg::MIN32, vau_pkg::MIN32,
                   vau_pkg::MIN32, vau_pkg::MIN32, 31'h0, 1'b0);
      end
      send_item(vau_pkg::FN_UNIT, 0, 0, 0, 5, 5, 5, 31'd0, 1'b0);
      send_item(vau_pkg::FN_UNIT, 0, vau_pkg::MIN32, 0, 0, 0, 0, 31'd0, 1'b0);
      send_item(vau_pkg::FN_UNIT, 1, -1, 0, 0, 0, 0, 31'd0, 1'b0);
      send_item(vau_pkg::FN_SPHERE, 0, 0, 32'sh10000, 0, 0, 32'sh50000, 31'h10000, 1'b1);
      send_item(vau_pkg::FN_SPHERE, 0, 0, 32'sh10000, 0, 0, 32'sh50000, 31'h60000, 1'b1);
      send_item(vau_pkg::FN_SPHERE, 0, 0, 32'sh10000, 0, 0, 32'sh50000, 31'h60000, 1'b0);
      send_item(vau_pkg::FN_SPHERE, vau_pkg::MAX32, vau_pkg::MAX32, 0, vau_pkg::MAX32,
                vau_pkg::MAX32, 0, 31'h7FFF_FFFF, 1'b1);
      send_item(vau_pkg::FN_MAG, 0, 0, 0, 0, 0, 0, 31'd0, 1'b0);
      send_item(vau_pkg::FN_SUB, vau_pkg::MAX32, vau_pkg::MIN32, 0, vau_pkg::MIN32,
                vau_pkg::MAX32, 0, 31'd0, 1'b0);
   endtask

   task automatic test_random(input int count, input int s_pct, input int r_pct);
      logic [2:0]  f;
      logic [30:0] rad;
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      for (int i = 0; i < count; i++) begin
         f = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
         rad = $urandom_range(0, 1) ? 31'($urandom()) : 31'($urandom_range(0, 1 << 22));
         send_item(f, rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                   rand_comp(), rad, 1'($urandom()));
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_random(430, 33, 70);
      test_random(430, 70, 33);
      test_random(440, 0, 0);
      @(negedge clock);
      req_valid = 1'b0;
      recv_idle_pct = 0;
      while (exp_rd_idx != exp_wr_idx) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end
endmodule
